// ===== rtl/ctl_pkg.sv =====
// Package for the C token lexer: item structs, phase enum, token kinds,
// character class and punctuator lookup functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ctl_pkg;

	localparam longint unsigned POSITION_LIMIT = 65535;
	localparam logic [15:0] POS_CAP = (POSITION_LIMIT < 65535) ? 16'(POSITION_LIMIT) : 16'hFFFF;

	localparam logic [5:0] K_NONE          = 6'd0;
	localparam logic [5:0] K_IDENT         = 6'd1;
	localparam logic [5:0] K_NUM           = 6'd2;
	localparam logic [5:0] K_CHAR          = 6'd3;
	localparam logic [5:0] K_STRING        = 6'd4;
	localparam logic [5:0] K_ELLIPSIS      = 6'd16;
	localparam logic [5:0] K_PERIOD        = 6'd17;
	localparam logic [5:0] K_LESS_LESS     = 6'd37;
	localparam logic [5:0] K_GREATER_GREATER = 6'd41;
	localparam logic [5:0] K_UNKNOWN       = 6'd53;

	typedef enum logic [4:0] {
		PH_IDLE, PH_SKIP, PH_END, PH_ID, PH_QUOTE, PH_ESC, PH_ALT1, PH_ALT2,
		PH_DOT, PH_DOT2, PH_ZERO, PH_OCT, PH_HEX, PH_HFRAC, PH_HEXP_SIGN,
		PH_HEXP_DIG, PH_DEC, PH_FRAC, PH_DEXP_SIGN, PH_DEXP_DIG, PH_FSUF,
		PH_ISUF, PH_ISUF_L, PH_ISUF_LL, PH_ISUF_U, PH_ISUF_UL
	} phase_t;

	typedef struct packed {
		logic        start_request;
		logic [15:0] start_position;
		logic [7:0]  character;
		logic        end_of_input;
	} in_item_t;

	typedef struct packed {
		logic [5:0]  token_kind;
		logic [15:0] token_length;
		logic [15:0] next_position;
		logic        last_token;
	} out_item_t;

	typedef struct packed {
		phase_t      phase;
		logic [15:0] pos;
		logic [15:0] beg;
		logic [5:0]  kind;
		logic [15:0] len;
		logic [3:0]  flags;
	} lex_state_t;

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		return (v < POS_CAP) ? v + 16'd1 : POS_CAP;
	endfunction

	function automatic logic [7:0] lower(input logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	function automatic logic is_ws(input logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_dig(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_oct(input logic [7:0] c);
		return c >= "0" && c <= "7";
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		logic [7:0] l;
		l = lower(c);
		return is_dig(c) || (l >= "a" && l <= "f");
	endfunction

	function automatic logic is_id_start(input logic [7:0] c);
		logic [7:0] l;
		l = lower(c);
		return c == "_" || c == "$" || (l >= "a" && l <= "z");
	endfunction

	// first punctuator character: kind, bit 6 set when longer spellings exist
	function automatic logic [6:0] punct_first(input logic [7:0] c);
		case (c)
			"[": return {1'b0, 6'd5};
			"]": return {1'b0, 6'd6};
			"(": return {1'b0, 6'd7};
			")": return {1'b0, 6'd8};
			"{": return {1'b0, 6'd9};
			"}": return {1'b0, 6'd10};
			"~": return {1'b0, 6'd11};
			"?": return {1'b0, 6'd12};
			":": return {1'b0, 6'd13};
			";": return {1'b0, 6'd14};
			",": return {1'b0, 6'd15};
			"-": return {1'b1, 6'd18};
			"+": return {1'b1, 6'd22};
			"&": return {1'b1, 6'd25};
			"*": return {1'b1, 6'd28};
			"!": return {1'b1, 6'd30};
			"/": return {1'b1, 6'd32};
			"%": return {1'b1, 6'd34};
			"<": return {1'b1, 6'd36};
			">": return {1'b1, 6'd40};
			"=": return {1'b1, 6'd44};
			"^": return {1'b1, 6'd46};
			"|": return {1'b1, 6'd48};
			"#": return {1'b1, 6'd51};
			default: return {1'b0, K_UNKNOWN};
		endcase
	endfunction

	function automatic logic [5:0] punct_second(input logic [5:0] k, input logic [7:0] c);
		case (k)
			6'd18: return (c == ">") ? 6'd19 : (c == "-") ? 6'd20 : (c == "=") ? 6'd21 : 6'd0;
			6'd22: return (c == "+") ? 6'd23 : (c == "=") ? 6'd24 : 6'd0;
			6'd25: return (c == "&") ? 6'd26 : (c == "=") ? 6'd27 : 6'd0;
			6'd36: return (c == "<") ? 6'd37 : (c == "=") ? 6'd39 : 6'd0;
			6'd40: return (c == ">") ? 6'd41 : (c == "=") ? 6'd43 : 6'd0;
			6'd48: return (c == "|") ? 6'd49 : (c == "=") ? 6'd50 : 6'd0;
			6'd51: return (c == "#") ? 6'd52 : 6'd0;
			6'd28, 6'd30, 6'd32, 6'd34, 6'd44, 6'd46:
				return (c == "=") ? k + 6'd1 : 6'd0;
			default: return 6'd0;
		endcase
	endfunction

endpackage
`default_nettype wire

// ===== rtl/ctl_step.sv =====
// One lexer step: consumes one registered input item against the current
// lexer state. Combinational. Depends on ctl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ctl_step import ctl_pkg::*; (
	input  wire in_item_t   item,
	input  wire lex_state_t cur,
	output lex_state_t      nxt,
	output logic            emit,
	output out_item_t       result
);

	always_comb begin
		logic       cv;
		logic       done;
		logic [7:0] c;
		logic [7:0] lc;
		logic [6:0] pf;
		logic [5:0] k2;
		lex_state_t s;

		s = cur;
		emit = 1'b0;
		result = '0;
		done = 1'b0;
		c = item.character;
		cv = !item.end_of_input;
		lc = cv ? lower(c) : 8'd0;
		pf = '0;
		k2 = '0;

		if (item.start_request) begin
			s.pos = (item.start_position > POS_CAP) ? POS_CAP : item.start_position;
			s.kind = K_NONE;
			s.len = '0;
			s.flags = '0;
			s.phase = PH_SKIP;
		end

		// resolve phase changes that do not consume the character
		for (int i = 0; i < 6; i++) begin
			if (!done) begin
				done = 1'b1;
				case (s.phase)
					PH_SKIP: begin
						if (!cv) begin
							emit = 1'b1;
							result = '{K_NONE, 16'd0, s.pos, 1'b1};
							s.phase = PH_IDLE;
						end else if (is_ws(c)) begin
							s.pos = sat_inc(s.pos);
						end else begin
							s.beg = s.pos;
							s.pos = sat_inc(s.pos);
							s.len = 16'd1;
							if (is_id_start(c)) begin
								s.kind = K_IDENT; s.phase = PH_ID;
							end else if (c == "0") begin
								s.kind = K_NUM; s.phase = PH_ZERO;
							end else if (is_dig(c)) begin
								s.kind = K_NUM; s.phase = PH_DEC;
							end else if (c == "'") begin
								s.kind = K_CHAR; s.phase = PH_QUOTE;
							end else if (c == "\"") begin
								s.kind = K_STRING; s.phase = PH_QUOTE;
							end else if (c == ".") begin
								s.kind = K_PERIOD; s.phase = PH_DOT;
							end else begin
								pf = punct_first(c);
								s.kind = pf[5:0];
								s.phase = pf[6] ? PH_ALT1 : PH_END;
							end
						end
					end
					PH_END: begin
						if (cv && is_ws(c)) begin
							s.pos = sat_inc(s.pos);
						end else begin
							emit = 1'b1;
							result = '{s.kind, s.len, s.pos, 1'b1};
							s.phase = PH_IDLE;
						end
					end
					PH_ID: begin
						if (cv && (is_id_start(c) || is_dig(c))) begin
							s.pos = sat_inc(s.pos); s.len = sat_inc(s.len);
						end else begin
							s.phase = PH_END; done = 1'b0;
						end
					end
					PH_QUOTE: begin
						if (!cv) begin
							s.phase = PH_END; done = 1'b0;
						end else begin
							s.pos = sat_inc(s.pos); s.len = sat_inc(s.len);
							if (c == "\\")
								s.phase = PH_ESC;
							else if (c == ((s.kind == K_CHAR) ? 8'h27 : 8'h22))
								s.phase = PH_END;
						end
					end
					PH_ESC: begin
						if (!cv) begin
							s.phase = PH_QUOTE; done = 1'b0;
						end else begin
							s.pos = sat_inc(s.pos); s.len = sat_inc(s.len);
							s.phase = PH_QUOTE;
						end
					end
					PH_ALT1: begin
						k2 = (cv && !is_ws(c)) ? punct_second(s.kind, c) : 6'd0;
						if (k2 == 6'd0) begin
							s.phase = PH_END; done = 1'b0;
						end else begin
							emit = 1'b1;
							result = '{s.kind, s.len, s.pos, 1'b0};
							s.kind = k2;
							s.pos = sat_inc(s.pos); s.len = sat_inc(s.len);
							s.flags = (k2 == K_LESS_LESS || k2 == K_GREATER_GREATER) ?
								4'd1 : 4'd0;
							s.phase = s.flags[0] ? PH_ALT2 : PH_END;
						end
					end
					PH_ALT2: begin
						if (!(cv && c == "=")) begin
							s.flags = '0; s.phase = PH_END; done = 1'b0;
						end else begin
							emit = 1'b1;
							result = '{s.kind, s.len, s.pos, 1'b0};
							s.kind = s.kind + 6'd1;
							s.pos = sat_inc(s.pos); s.len = sat_inc(s.len);
							s.flags = '0;
							s.phase = PH_END;
						end
					end
					PH_DOT: begin
						if (cv && is_dig(c)) begin
							s.kind = K_NUM;
							s.pos = sat_inc(s.pos); s.len = sat_inc(s.len);
							s.phase = PH_FRAC;
						end else if (cv && c == ".") begin
							s.pos = sat_inc(s.pos); s.len = sat_inc(s.len);
							s.phase = PH_DOT2;
						end else begin
							s.phase = PH_END; done = 1'b0;
						end
					end
					PH_DOT2: begin
						if (cv && c == ".") begin
							s.kind = K_ELLIPSIS;
							s.pos = sat_inc(s.pos); s.len = sat_inc(s.len);
							s.phase = PH_END;
						end else begin
							// two dots: report one period, restart after it
							emit = 1'b1;
							result = '{K_PERIOD, 16'd1, sat_inc(s.beg), 1'b1};
							s.phase = PH_IDLE;
						end
					end
					PH_ZERO: begin
						if (cv && c == ".") begin
							s.pos = sat_inc(s.pos); s.len = sat_inc(s.len);
							s.phase = PH_FRAC;
						end else if (lc == "x") begin
							s.pos = sat_inc(s.pos); s.len = sat_inc(s.len);
							s.phase = PH_HEX;
						end else begin
							s.phase = PH_OCT; done = 1'b0;
						end
					end
					PH_OCT: begin
						if (cv && is_oct(c)) begin
							s.pos = sat_inc(s.pos); s.len = sat_inc(s.len);
						end else begin
							s.phase = PH_ISUF; done = 1'b0;
						end
					end
					PH_HEX: begin
						if (cv && is_hex(c)) begin
							s.pos = sat_inc(s.pos); s.len = sat_inc(s.len);
						end else if (cv && c == ".") begin
							s.pos = sat_inc(s.pos); s.len = sat_inc(s.len);
							s.phase = PH_HFRAC;
						end else if (lc == "p") begin
							s.pos = sat_inc(s.pos); s.len = sat_inc(s.len);
							s.phase = PH_HEXP_SIGN;
						end else begin
							s.phase = PH_ISUF; done = 1'b0;
						end
					end
					PH_HFRAC: begin
						if (cv && is_hex(c)) begin
							s.pos = sat_inc(s.pos); s.len = sat_inc(s.len);
						end else if (lc == "p") begin
							s.pos = sat_inc(s.pos); s.len = sat_inc(s.len);
							s.phase = PH_HEXP_SIGN;
						end else begin
							s.phase = PH_FSUF; done = 1'b0;
						end
					end
					PH_HEXP_SIGN, PH_DEXP_SIGN: begin
						s.phase = (s.phase == PH_HEXP_SIGN) ? PH_HEXP_DIG : PH_DEXP_DIG;
						if (cv && (c == "+" || c == "-")) begin
							s.pos = sat_inc(s.pos); s.len = sat_inc(s.len);
						end else begin
							done = 1'b0;
						end
					end
					PH_HEXP_DIG: begin
						if (cv && is_hex(c)) begin
							s.pos = sat_inc(s.pos); s.len = sat_inc(s.len);
						end else begin
							s.phase = PH_FSUF; done = 1'b0;
						end
					end
					PH_DEC: begin
						if (cv && is_dig(c)) begin
							s.pos = sat_inc(s.pos); s.len = sat_inc(s.len);
						end else if (cv && c == ".") begin
							s.pos = sat_inc(s.pos); s.len = sat_inc(s.len);
							s.phase = PH_FRAC;
						end else if (lc == "e") begin
							s.pos = sat_inc(s.pos); s.len = sat_inc(s.len);
							s.phase = PH_DEXP_SIGN;
						end else begin
							s.phase = PH_ISUF; done = 1'b0;
						end
					end
					PH_FRAC: begin
						if (cv && is_dig(c)) begin
							s.pos = sat_inc(s.pos); s.len = sat_inc(s.len);
						end else if (lc == "e") begin
							s.pos = sat_inc(s.pos); s.len = sat_inc(s.len);
							s.phase = PH_DEXP_SIGN;
						end else begin
							s.phase = PH_FSUF; done = 1'b0;
						end
					end
					PH_DEXP_DIG: begin
						if (cv && is_dig(c)) begin
							s.pos = sat_inc(s.pos); s.len = sat_inc(s.len);
						end else begin
							s.phase = PH_FSUF; done = 1'b0;
						end
					end
					PH_FSUF: begin
						s.phase = PH_END;
						if (lc == "f" || lc == "l") begin
							s.pos = sat_inc(s.pos); s.len = sat_inc(s.len);
						end else begin
							done = 1'b0;
						end
					end
					PH_ISUF: begin
						if (lc == "l") begin
							s.pos = sat_inc(s.pos); s.len = sat_inc(s.len);
							s.phase = PH_ISUF_L;
						end else if (lc == "u") begin
							s.pos = sat_inc(s.pos); s.len = sat_inc(s.len);
							s.phase = PH_ISUF_U;
						end else begin
							s.phase = PH_END; done = 1'b0;
						end
					end
					PH_ISUF_L: begin
						if (lc == "l") begin
							s.pos = sat_inc(s.pos); s.len = sat_inc(s.len);
							s.phase = PH_ISUF_LL;
						end else begin
							s.phase = PH_END;
							if (lc == "u") begin
								s.pos = sat_inc(s.pos); s.len = sat_inc(s.len);
							end else begin
								done = 1'b0;
							end
						end
					end
					PH_ISUF_LL: begin
						s.phase = PH_END;
						if (lc == "u") begin
							s.pos = sat_inc(s.pos); s.len = sat_inc(s.len);
						end else begin
							done = 1'b0;
						end
					end
					PH_ISUF_U: begin
						if (lc == "l") begin
							s.pos = sat_inc(s.pos); s.len = sat_inc(s.len);
							s.phase = PH_ISUF_UL;
						end else begin
							s.phase = PH_END; done = 1'b0;
						end
					end
					PH_ISUF_UL: begin
						s.phase = PH_END;
						if (lc == "l") begin
							s.pos = sat_inc(s.pos); s.len = sat_inc(s.len);
						end else begin
							done = 1'b0;
						end
					end
					default: begin
						s.phase = PH_IDLE;
					end
				endcase
			end
		end
		nxt = s;
	end

endmodule
`default_nettype wire

// ===== rtl/c_token_lexer_all_alternatives.sv =====
// C token lexer top level: input register, lexer state, result register.
// Depends on ctl_pkg and ctl_step.
//
// Usage:
//  - Input channel (in_valid / in_stall / in_data): one character or end
//    mark per transfer. A transfer with start_request set opens a request at
//    start_position; a request in progress is dropped without a result.
//  - Output channel (out_valid / out_stall / out_data): token results. A
//    punctuator (not an ellipsis) gives one result per spelling that starts
//    at it, shortest first; last_token marks the final result of a request.
//  - Between a request's last result and the next start, characters are
//    taken and ignored.
//  - Throughput: one input transfer per cycle unless the output stalls.
//  - Path: an input transfer is registered, then stepped through the lexer
//    state once the result register is free or draining, and its result
//    lands in the output register, which drives out_data.
//  - Stall: while out_stall holds a result, the stepping stage waits, and
//    in_stall rises once the input register is occupied as well.
//  - Reset (arst_n low): lexer idle, both registers empty.
`timescale 1ns / 1ps
`default_nettype none
module c_token_lexer_all_alternatives import ctl_pkg::*; (
	input  wire       clk,
	input  wire       arst_n,
	input  wire       in_valid,
	output logic      in_stall,
	input  wire in_item_t in_data,
	output logic      out_valid,
	input  wire       out_stall,
	output out_item_t out_data
);

	logic       valid_s1;
	in_item_t   item_s1;
	lex_state_t state_q;
	lex_state_t state_nxt;
	logic       step_emit;
	out_item_t  step_out;
	logic       out_valid_q;
	out_item_t  out_q;
	logic       advance;
	logic       step_fire;

	// stepping stage moves when the result register is free or draining
	assign advance   = !out_valid_q || !out_stall;
	assign step_fire = valid_s1 && advance;
	assign in_stall  = valid_s1 && !advance;

	ctl_step u_step (
		.item   (item_s1),
		.cur    (state_q),
		.nxt    (state_nxt),
		.emit   (step_emit),
		.result (step_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{PH_IDLE, 16'd0, 16'd0, K_NONE, 16'd0, 4'd0};
		end else if (step_fire) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step_fire && step_emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step_fire && step_emit) begin
			out_q <= step_out;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	a_last_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step_fire && step_emit && step_out.last_token) |=> (state_q.phase == PH_IDLE))
		else $error("lexer not idle after final result");

	a_flags_in_alt2: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.flags != 4'd0) |-> (state_q.phase == PH_ALT2))
		else $error("shift-assign flag outside its phase");

endmodule
`default_nettype wire
